/* design/fsi_pkg.sv */
// fsi_pkg: shared widths, field positions, codes, the arithmetic request struct
// and the saturation helper for the fractional sample interpolator.
// No dependencies.
`default_nettype none

package fsi_pkg;

  localparam int FSI_STORE_DEPTH = 1024;
  localparam int SAMPLE_BITS     = 16;
  localparam int FRAC_BITS       = 16;
  localparam int POS_BITS        = 27;
  localparam int WIDX_BITS       = 10;
  localparam int CNT_BITS        = 11;

  // input tdata packing, lowest field first
  localparam int WIDX_LSB    = 0;
  localparam int SVAL_LSB    = WIDX_LSB + WIDX_BITS;
  localparam int POS_LSB     = SVAL_LSB + SAMPLE_BITS;
  localparam int IN_FIELDS_W = POS_LSB + POS_BITS;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = CNT_BITS;
  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 1'd1;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic MODE_LINEAR = 1'b0;
  localparam logic MODE_CUBIC  = 1'b1;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_BAD_SIZE = 1'b1;

  // datapath widths
  localparam int ACC_W  = SAMPLE_BITS + 6;
  localparam int PROD_W = ACC_W + FRAC_BITS + 1;
  localparam int RES_W  = PROD_W - FRAC_BITS + 1;
  localparam int CMP_W  = CNT_BITS + FRAC_BITS + 1;

  localparam logic signed [RES_W-1:0] SAT_HI = RES_W'(2 ** (SAMPLE_BITS - 1) - 1);
  localparam logic signed [RES_W-1:0] SAT_LO = -SAT_HI - RES_W'(1);

  typedef struct packed {
    logic                              cubic;
    logic [FRAC_BITS-1:0]              t;
    logic [3:0][SAMPLE_BITS-1:0]       p;
  } fsi_op_t;

  function automatic logic [SAMPLE_BITS-1:0] fsi_sat(input logic signed [RES_W-1:0] v);
    logic [SAMPLE_BITS-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[SAMPLE_BITS-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      r = v[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/fsi_ram.sv */
// fsi_ram: generic single-write, single-read synchronous RAM with registered
// read data. No dependencies.
`default_nettype none

module fsi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* design/fsi_arith.sv */
// fsi_arith: shared-multiplier sequencer for linear and Catmull-Rom blending,
// rounding and saturation. Depends on fsi_pkg.
`default_nettype none

module fsi_arith import fsi_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire fsi_op_t                op,
  output logic                        busy,
  output logic                        done,
  output logic [SAMPLE_BITS-1:0]      result
);

  localparam logic [2:0] STEP_MUL1 = 3'd1;
  localparam logic [2:0] STEP_ACC1 = 3'd2;
  localparam logic [2:0] STEP_MUL2 = 3'd3;
  localparam logic [2:0] STEP_ACC2 = 3'd4;
  localparam logic [2:0] STEP_MUL3 = 3'd5;
  localparam logic [2:0] STEP_FIN  = 3'd6;

  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(2 ** (FRAC_BITS - 1));
  localparam logic signed [PROD_W:0]   ONE  = (PROD_W + 1)'(2 ** FRAC_BITS);

  logic [2:0]                 step;
  logic                       running;
  logic                       cubic;
  logic [FRAC_BITS-1:0]       t;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    c1;
  logic signed [ACC_W-1:0]    c2;
  logic signed [ACC_W-1:0]    base;
  logic signed [PROD_W-1:0]   prod;

  logic signed [ACC_W-1:0]    s0, s1, s2, s3, d12;
  logic signed [ACC_W-1:0]    c3_in;
  logic signed [FRAC_BITS:0]  t_s;
  logic signed [PROD_W-1:0]   mul;
  logic signed [ACC_W-1:0]    prod_fl;
  logic signed [PROD_W-1:0]   lin_sum;
  logic signed [RES_W-1:0]    lin_res;
  logic signed [PROD_W:0]     cub_sum;
  logic signed [RES_W-1:0]    cub_res;

  assign s0  = ACC_W'($signed(op.p[0]));
  assign s1  = ACC_W'($signed(op.p[1]));
  assign s2  = ACC_W'($signed(op.p[2]));
  assign s3  = ACC_W'($signed(op.p[3]));
  assign d12 = s1 - s2;
  assign c3_in = (d12 <<< 1) + d12 + s3 - s0;

  assign t_s     = $signed({1'b0, t});
  assign mul     = acc * t_s;
  assign prod_fl = ACC_W'(prod >>> FRAC_BITS);

  // linear: a + floor(((b - a) * t + half) / 2^F)
  assign lin_sum = prod + HALF;
  assign lin_res = RES_W'(lin_sum >>> FRAC_BITS) + RES_W'(base);

  // cubic: floor((2 * p1 * 2^F + v * t + 2^F) / 2^(F+1))
  assign cub_sum = (PROD_W + 1)'(prod) + ((PROD_W + 1)'(base) <<< (FRAC_BITS + 1)) + ONE;
  assign cub_res = RES_W'(cub_sum >>> (FRAC_BITS + 1));

  assign busy = running;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= STEP_MUL1;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= STEP_MUL1;
        cubic   <= op.cubic;
        t       <= op.t;
        base    <= s1;
        c1      <= s2 - s0;
        c2      <= (s0 <<< 1) - (s1 <<< 2) - s1 + (s2 <<< 2) - s3;
        acc     <= (op.cubic == MODE_CUBIC) ? c3_in : (s2 - s1);
      end else if (running) begin
        case (step)
          STEP_MUL1, STEP_MUL2, STEP_MUL3: begin
            prod <= mul;
            step <= step + 3'd1;
          end
          STEP_ACC1: begin
            if (cubic == MODE_CUBIC) begin
              acc  <= prod_fl + c2;
              step <= STEP_MUL2;
            end else begin
              result  <= fsi_sat(lin_res);
              done    <= 1'b1;
              running <= 1'b0;
            end
          end
          STEP_ACC2: begin
            acc  <= prod_fl + c1;
            step <= STEP_MUL3;
          end
          STEP_FIN: begin
            result  <= fsi_sat(cub_res);
            done    <= 1'b1;
            running <= 1'b0;
          end
          default: begin
            running <= 1'b0;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

/* design/fractional_sample_interpolator.sv */
// Fractional sample interpolator. A write request (tuser 0) stores one signed
// sample at a slot of the sample RAM in the cycle it is taken. A query request
// (tuser 1) returns one result: the value at a signed position with FRAC_BITS
// fraction bits, blended linearly or by a uniform Catmull-Rom cubic (neighbour
// slots clamped at the ends), rounded and saturated; positions at or below zero
// and at or past count-1 return the end samples, and a sample count of zero
// returns status 1 with value 0. The state lives in one synchronous RAM with a
// single read port, so a query fetches its neighbours one per cycle; with the
// shared multiplier a query steps through the prepare, read, drain, start and
// calculate states before it loads the output register, and the next request
// is taken once that result is loaded, so a query occupies the block until the
// output register has room for its result; a write does not hold the block. Results
// wait in the output register while the block takes the next request.
// Depends on fsi_pkg, fsi_ram and fsi_arith.
`default_nettype none

module fractional_sample_interpolator import fsi_pkg::*; #(
  parameter int STORE_DEPTH = FSI_STORE_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // write_index, sample_value, position, zero pad
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // func
  input  wire logic                  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // interp_value
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // status
  output logic                       m_axis_tuser
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam logic [CNT_BITS-1:0] DEPTH_CAP = CNT_BITS'(STORE_DEPTH);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PREP  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_GO    = 3'd4;
  localparam logic [2:0] ST_CALC  = 3'd5;
  localparam logic [2:0] ST_HOLD  = 3'd6;

  logic [2:0]                  state;
  logic                        mode;
  logic [CNT_BITS-1:0]         count;
  logic [POS_BITS-1:0]         q_pos;
  logic [CNT_BITS-1:0]         addr [4];
  logic [1:0]                  rd_slot;
  logic [1:0]                  end_slot;
  logic                        cap_valid;
  logic [1:0]                  cap_slot;
  logic [3:0][SAMPLE_BITS-1:0] p;
  logic [FRAC_BITS-1:0]        t;
  logic                        cubic;
  logic                        bad_size;

  logic                        in_acc;
  logic [WIDX_BITS-1:0]        w_idx;
  logic                        ram_we;
  logic [SAMPLE_BITS-1:0]      ram_rdata;

  logic [CNT_BITS-1:0]         n;
  logic [CNT_BITS-1:0]         last;
  logic                        pos_le0;
  logic                        pos_ge;
  logic [CNT_BITS-1:0]         ipart;
  logic [CNT_BITS-1:0]         i0, i2, i3, ip2;

  fsi_op_t                     op;
  logic                        arith_busy;
  logic                        arith_done;
  logic [SAMPLE_BITS-1:0]      arith_res;
  logic                        out_free;
  logic                        out_load;

  assign s_axis_tready = (state == ST_IDLE) && !rst;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign w_idx         = s_axis_tdata[WIDX_LSB +: WIDX_BITS];
  assign ram_we        = in_acc && (s_axis_tuser == FUNC_WRITE) && (32'(w_idx) < STORE_DEPTH);

  fsi_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(w_idx)),
    .wdata (s_axis_tdata[SVAL_LSB +: SAMPLE_BITS]),
    .raddr (AW'(addr[rd_slot])),
    .rdata (ram_rdata)
  );

  // query decode
  assign n       = (32'(count) > STORE_DEPTH) ? DEPTH_CAP : count;
  assign last    = n - CNT_BITS'(1);
  assign pos_le0 = q_pos[POS_BITS-1] || (q_pos == '0);
  assign pos_ge  = CMP_W'(q_pos[POS_BITS-2:0]) >= CMP_W'({last, {FRAC_BITS{1'b0}}});
  assign ipart   = CNT_BITS'(q_pos[POS_BITS-2:FRAC_BITS]);
  assign i0      = (ipart == '0) ? '0 : ipart - CNT_BITS'(1);
  assign i2      = ipart + CNT_BITS'(1);
  assign ip2     = ipart + CNT_BITS'(2);
  assign i3      = (ip2 <= last) ? ip2 : last;

  assign op.cubic = cubic;
  assign op.t     = t;
  assign op.p     = p;

  fsi_arith u_arith (
    .clk    (clk),
    .rst    (rst),
    .start  (state == ST_GO),
    .op     (op),
    .busy   (arith_busy),
    .done   (arith_done),
    .result (arith_res)
  );

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign out_load = (state == ST_HOLD) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_LINEAR;
      count <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:  mode  <= cfg_data[0];
        REG_COUNT: count <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cap_valid <= 1'b0;
      rd_slot   <= 2'd0;
      end_slot  <= 2'd0;
      bad_size  <= 1'b0;
    end else begin
      cap_valid <= (state == ST_READ);
      cap_slot  <= rd_slot;
      if (cap_valid) begin
        p[cap_slot] <= ram_rdata;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc && (s_axis_tuser == FUNC_QUERY)) begin
            q_pos <= s_axis_tdata[POS_LSB +: POS_BITS];
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          if (n == '0) begin
            bad_size <= 1'b1;
            state    <= ST_HOLD;
          end else begin
            bad_size <= 1'b0;
            state    <= ST_READ;
            if (pos_le0 || pos_ge) begin
              // end sample: linear blend of one sample with itself at t = 0
              addr[1]  <= pos_le0 ? '0 : last;
              addr[2]  <= pos_le0 ? '0 : last;
              t        <= '0;
              cubic    <= MODE_LINEAR;
              rd_slot  <= 2'd1;
              end_slot <= 2'd2;
            end else begin
              addr[0]  <= i0;
              addr[1]  <= ipart;
              addr[2]  <= i2;
              addr[3]  <= i3;
              t        <= q_pos[FRAC_BITS-1:0];
              cubic    <= mode;
              rd_slot  <= (mode == MODE_CUBIC) ? 2'd0 : 2'd1;
              end_slot <= (mode == MODE_CUBIC) ? 2'd3 : 2'd2;
            end
          end
        end
        ST_READ: begin
          if (rd_slot == end_slot) begin
            state <= ST_DRAIN;
          end else begin
            rd_slot <= rd_slot + 2'd1;
          end
        end
        ST_DRAIN: state <= ST_GO;
        ST_GO:    state <= ST_CALC;
        ST_CALC: begin
          if (arith_done) begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= bad_size ? '0 : OUT_DATA_W'(arith_res);
      m_axis_tuser <= bad_size ? STATUS_BAD_SIZE : STATUS_OK;
    end
  end

  a_done_in_calc: assert property (@(posedge clk) disable iff (rst)
    arith_done |-> (state == ST_CALC))
    else $error("arithmetic finished outside the calc state");

  a_idle_not_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !arith_busy)
    else $error("request taken while arithmetic busy");

  a_read_window: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> (rd_slot <= end_slot))
    else $error("read slot past last fetch");

  a_bad_size_out: assert property (@(posedge clk) disable iff (rst)
    (out_load && bad_size) |=> (m_axis_tvalid && m_axis_tuser == STATUS_BAD_SIZE
                                && m_axis_tdata == '0))
    else $error("zero count result malformed");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// tb_top: self-checking bench for fractional_sample_interpolator. Covers linear and
// cubic interpolation, end clamping, zero and oversized counts, and saturation.
// Depends on fsi_pkg and fractional_sample_interpolator; stalls both streams at random.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fsi_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 24;
  localparam int MAX_REPORTS    = 10;
  localparam int PHASES         = 10;
  localparam int PHASE_ITEMS    = 18;
  localparam longint ONE        = longint'(1) << FRAC_BITS;
  localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
  localparam logic [POS_BITS-1:0] POS_MAX = {1'b0, {(POS_BITS - 1){1'b1}}};
  localparam logic [POS_BITS-1:0] POS_MIN = {1'b1, {(POS_BITS - 1){1'b0}}};

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          status;
  } interp_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;

  logic signed [SAMPLE_BITS-1:0] sample_mirror [FSI_STORE_DEPTH];
  logic                          mode_sel = MODE_LINEAR;
  int unsigned                   count_reg = 0;
  interp_result_t                pending_results [$];
  int                            fail_count = 0;
  int                            results_seen = 0;
  int                            idle_cycles = 0;
  int                            rx_hold = 0;
  bit                            no_gaps = 1'b0;

  always #5 clk = ~clk;

  fractional_sample_interpolator DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  function automatic int gap_len();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic interp_result_t interp_at(input logic signed [POS_BITS-1:0] pos);
    interp_result_t res;
    longint n, last, p, i, t, p0, p1, p2, p3, c1, c2, c3, v, r;
    res.status = STATUS_OK;
    res.value  = '0;
    n = (count_reg > FSI_STORE_DEPTH) ? FSI_STORE_DEPTH : count_reg;
    if (n == 0) begin
      res.status = STATUS_BAD_SIZE;
      return res;
    end
    last = n - 1;
    p = pos;
    if (p <= 0) begin
      r = sample_mirror[0];
    end else if (p >= last * ONE) begin
      r = sample_mirror[last];
    end else begin
      i  = p >>> FRAC_BITS;
      t  = p & (ONE - 1);
      p1 = sample_mirror[i];
      p2 = sample_mirror[i + 1];
      if (mode_sel == MODE_LINEAR) begin
        r = (p1 * (ONE - t) + p2 * t + (ONE >>> 1)) >>> FRAC_BITS;
      end else begin
        // neighbours clamped to the valid range
        p0 = sample_mirror[(i == 0) ? 0 : i - 1];
        p3 = sample_mirror[(i + 2 <= last) ? i + 2 : last];
        c1 = p2 - p0;
        c2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        c3 = 3 * (p1 - p2) + p3 - p0;
        v  = ((c3 * t) >>> FRAC_BITS) + c2;
        v  = ((v * t) >>> FRAC_BITS) + c1;
        r  = (2 * p1 * ONE + v * t + ONE) >>> (FRAC_BITS + 1);
      end
    end
    if (r > SAMPLE_MAX) r = SAMPLE_MAX;
    if (r < SAMPLE_MIN) r = SAMPLE_MIN;
    res.value = SAMPLE_BITS'(r);
    return res;
  endfunction

  function automatic logic [POS_BITS-1:0] pick_position(input int unsigned count);
    int unsigned n, r, span;
    longint      off;
    n    = (count > FSI_STORE_DEPTH) ? FSI_STORE_DEPTH : count;
    span = (n == 0) ? 0 : (n - 1) << FRAC_BITS;
    r    = $urandom_range(0, 9);
    off  = longint'($urandom_range(0, 4)) - 2;
    if (r == 0) return POS_BITS'($urandom);
    if (r == 1) return POS_BITS'(longint'(span) + off);
    if (r == 2) return POS_BITS'(off);
    return POS_BITS'($urandom_range(0, span));
  endfunction

  function automatic void flag_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%t mismatch: %s", $realtime, msg);
  endfunction

  task automatic send_item(input logic fn, input logic [WIDX_BITS-1:0] widx,
                           input logic [SAMPLE_BITS-1:0] sval,
                           input logic [POS_BITS-1:0] pos);
    logic [IN_DATA_W-1:0] word;
    int                   gap;
    gap  = gap_len();
    word = '0;
    word[WIDX_LSB +: WIDX_BITS]  = widx;
    word[SVAL_LSB +: SAMPLE_BITS] = sval;
    word[POS_LSB +: POS_BITS]     = pos;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= fn;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (fn == FUNC_WRITE) begin
      sample_mirror[widx] = sval;
    end else begin
      pending_results.push_back(interp_at(pos));
    end
  endtask

  task automatic send_write(input int unsigned slot, input logic [SAMPLE_BITS-1:0] sval);
    send_item(FUNC_WRITE, WIDX_BITS'(slot), sval, POS_BITS'($urandom));
  endtask

  task automatic send_query(input logic [POS_BITS-1:0] pos);
    send_item(FUNC_QUERY, WIDX_BITS'($urandom), SAMPLE_BITS'($urandom), pos);
  endtask

  // drain all results, then let a trailing write settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic mode, input int unsigned count);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MODE;
    cfg_data  <= CFG_DATA_W'(mode);
    @(posedge clk);
    cfg_index <= REG_COUNT;
    cfg_data  <= CFG_DATA_W'(count);
    @(posedge clk);
    cfg_we    <= 1'b0;
    mode_sel  = mode;
    count_reg = count & ((1 << CFG_DATA_W) - 1);
  endtask

  task automatic test_zero_count();
    set_config(MODE_LINEAR, 0);
    send_query(POS_MAX);
    send_query(POS_MIN);
    wait_idle();
    set_config(MODE_CUBIC, 0);
    send_query(POS_BITS'(ONE / 2));
    wait_idle();
  endtask

  task automatic test_linear_ends();
    set_config(MODE_LINEAR, 4);
    send_write(0, 16'sh7FFF);
    send_write(1, 16'sh8000);
    send_write(2, 16'sh0000);
    send_write(3, 16'sd12345);
    send_query(POS_MIN);
    send_query(POS_BITS'(1));
    send_query(POS_BITS'(ONE / 2));
    send_query(POS_BITS'(3 * ONE - 1));
    send_query(POS_BITS'(3 * ONE));
    send_query(POS_MAX);
    wait_idle();
  endtask

  task automatic test_cubic_ends();
    set_config(MODE_CUBIC, 4);
    send_query(POS_BITS'(ONE / 4));
    send_query(POS_BITS'(ONE + ONE / 2));
    send_query(POS_BITS'(2 * ONE + 3 * ONE / 4));
    wait_idle();
    set_config(MODE_CUBIC, 2);
    send_query(POS_BITS'(ONE / 2));
    wait_idle();
    set_config(MODE_CUBIC, 1);
    send_query(POS_BITS'(ONE / 2));
    wait_idle();
  endtask

  // steep steps make the spline overshoot both rails
  task automatic test_cubic_saturation();
    set_config(MODE_CUBIC, 6);
    send_write(0, 16'sh8000);
    send_write(1, 16'sh7FFF);
    send_write(2, 16'sh7FFF);
    send_write(3, 16'sh8000);
    send_write(4, 16'sh8000);
    send_write(5, 16'sh7FFF);
    send_query(POS_BITS'(ONE + ONE / 2));
    send_query(POS_BITS'(3 * ONE + ONE / 2));
    wait_idle();
  endtask

  task automatic test_full_store();
    int k;
    set_config(MODE_LINEAR, FSI_STORE_DEPTH);
    no_gaps = 1'b1;
    for (k = 0; k < FSI_STORE_DEPTH; k++) send_write(k, SAMPLE_BITS'($urandom));
    no_gaps = 1'b0;
    send_query(POS_MAX);
    send_query(POS_BITS'((FSI_STORE_DEPTH - 1) * ONE));
    send_query(POS_BITS'((FSI_STORE_DEPTH - 1) * ONE - 1));
    for (k = 0; k < 10; k++) send_query(pick_position(FSI_STORE_DEPTH));
    wait_idle();
    // count beyond the store depth acts as a full store
    set_config(MODE_CUBIC, (1 << CFG_DATA_W) - 1);
    send_query(POS_MAX);
    send_query(POS_BITS'((FSI_STORE_DEPTH - 1) * ONE - 1));
    for (k = 0; k < 10; k++) send_query(pick_position(FSI_STORE_DEPTH));
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int          ph, k, r;
    int unsigned count, n;
    logic        mode;
    for (ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      r = $urandom_range(0, 19);
      if (r == 0) count = 0;
      else if (r < 8) count = $urandom_range(1, 8);
      else if (r < 17) count = $urandom_range(9, FSI_STORE_DEPTH);
      else if (r < 19) count = FSI_STORE_DEPTH;
      else count = $urandom_range(FSI_STORE_DEPTH + 1, (1 << CFG_DATA_W) - 1);
      mode = 1'($urandom_range(0, 1));
      set_config(mode, count);
      n = (count > FSI_STORE_DEPTH) ? FSI_STORE_DEPTH : count;
      no_gaps = (ph == PHASES / 2);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 3) == 0) begin
          if (n > 0 && $urandom_range(0, 3) != 0) send_write($urandom_range(0, n - 1),
                                                             SAMPLE_BITS'($urandom));
          else send_write($urandom_range(0, FSI_STORE_DEPTH - 1), SAMPLE_BITS'($urandom));
        end else begin
          send_query(pick_position(count));
        end
      end
    end
    no_gaps = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rx_hold > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold       <= rx_hold - 1;
    end else begin
      m_axis_tready <= 1'b1;
      rx_hold       <= gap_len();
    end
  end

  always @(posedge clk) begin
    interp_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        flag_failure($sformatf("result with nothing expected: value %0d status %0d",
                               $signed(m_axis_tdata[SAMPLE_BITS-1:0]), m_axis_tuser));
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[SAMPLE_BITS-1:0] !== want.value || m_axis_tuser !== want.status) begin
          flag_failure($sformatf("result %0d: expected value %0d status %0d, got %0d status %0d",
                                 results_seen, want.value, want.status,
                                 $signed(m_axis_tdata[SAMPLE_BITS-1:0]), m_axis_tuser));
        end
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_zero_count();
    test_linear_ends();
    test_cubic_ends();
    test_cubic_saturation();
    test_full_store();
    test_random_traffic();
    wait_idle();
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
